[hdl/btree_internal_node_unit_assert.svh]
// ---------------------------------------------------------------------------
// B+ tree internal node unit assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BTREE_INTERNAL_NODE_UNIT_ASSERT_SVH
`define BTREE_INTERNAL_NODE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BTNI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BTNI_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define BTNI_ASSERT(label, prop, msg)
`define BTNI_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

[hdl/btni_pkg.sv]
// ---------------------------------------------------------------------------
// B+ tree internal node package
// Sizes, command and result codes, and request and result types.
// ---------------------------------------------------------------------------
package btni_pkg;

  localparam int KeySlots = 16;
  localparam int Mid      = (KeySlots + 1) / 2;
  localparam int CntW     = $clog2(KeySlots + 1);
  localparam int KeyDepth = KeySlots + 1;
  localparam int ChdDepth = KeySlots + 2;
  localparam int KeyAw    = $clog2(KeyDepth);
  localparam int ChdAw    = $clog2(ChdDepth);

  localparam logic [1:0] CmdLookup = 2'd0;
  localparam logic [1:0] CmdInsert = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;

  localparam logic [1:0] KindLookup = 2'd0;
  localparam logic [1:0] KindDone   = 2'd1;
  localparam logic [1:0] KindSplit  = 2'd2;
  localparam logic [1:0] KindMoved  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] key;
    logic [31:0] child;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] key_res;
    logic [31:0] child_res;
    logic [4:0]  count;
    logic        last;
  } rsp_t;

endpackage

[hdl/btree_internal_node_unit.sv]
// ---------------------------------------------------------------------------
// B+ tree internal node unit
// One sorted internal node with lookup, sorted insert, split and clear.
// ---------------------------------------------------------------------------
// A request on the input channel carries a command, a key and a child id. A
// request is taken when in_valid_i is high and in_stall_o is low; the unit
// works on one request at a time and takes the next one only after the last
// result of the previous one has left the output register.
// Keys and children live in two RAMs with registered read data.
// A clear loads its result into the output register when it is taken. A
// lookup scans keys upward, one key every cycle, then reads the child. An
// insert shifts larger entries up from the top, one entry a cycle, then
// writes the new entry. A full node then splits: it reads back the boundary
// and moved entries, each output once the output register is free, giving
// KEY_SLOTS/2 + 1 results. Command 3 is dropped without a result.
// Reset clears the key count and the control state; RAM contents stay
// undefined until written. When the receiver stalls, the output register
// holds its result and the unit waits before loading the next one.
// ---------------------------------------------------------------------------
`include "btree_internal_node_unit_assert.svh"

module btree_internal_node_unit
  import btni_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StLkKey    = 3'd1;
  localparam logic [2:0] StLkChild  = 3'd2;
  localparam logic [2:0] StShift    = 3'd3;
  localparam logic [2:0] StPut      = 3'd4;
  localparam logic [2:0] StSplitRd  = 3'd5;
  localparam logic [2:0] StSplitOut = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  req_t            req_q, req_d;
  rsp_t            out_q, out_d;
  logic            out_valid_q;
  logic            out_load, out_free, in_acc;

  logic             k_we;
  logic [KeyAw-1:0] k_waddr, k_raddr;
  logic [15:0]      k_wdata, k_rdata;
  logic             c_we;
  logic [ChdAw-1:0] c_waddr, c_raddr;
  logic [31:0]      c_wdata, c_rdata;

  btni_ram #(.Width(16), .Depth(KeyDepth)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  btni_ram #(.Width(32), .Depth(ChdDepth)) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  assign in_stall_o = (state_q != StIdle) || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    req_d    = req_q;
    k_we     = 1'b0;
    k_waddr  = '0;
    k_wdata  = '0;
    k_raddr  = KeyAw'(idx_q);
    c_we     = 1'b0;
    c_waddr  = '0;
    c_wdata  = '0;
    c_raddr  = '0;
    out_load = 1'b0;
    out_d    = '0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          req_d = in_req_i;
          unique case (in_req_i.cmd)
            CmdLookup: begin
              if (cnt_q == CntW'(0)) begin
                c_raddr = '0;
                state_d = StLkChild;
              end else begin
                idx_d   = '0;
                k_raddr = '0;
                state_d = StLkKey;
              end
            end
            CmdClear: begin
              c_we     = 1'b1;
              c_waddr  = '0;
              c_wdata  = in_req_i.child;
              cnt_d    = '0;
              out_load = 1'b1;
              out_d    = '{KindDone, in_req_i.key, in_req_i.child, 5'd0, 1'b1};
            end
            CmdInsert: begin
              if (cnt_q == CntW'(0)) begin
                pos_d   = '0;
                state_d = StPut;
              end else begin
                idx_d   = cnt_q - CntW'(1);
                k_raddr = KeyAw'(cnt_q - CntW'(1));
                c_raddr = ChdAw'(cnt_q);
                state_d = StShift;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StLkKey: begin
        if (k_rdata > req_q.key) begin
          c_raddr = ChdAw'(idx_q);
          state_d = StLkChild;
        end else if ((idx_q + CntW'(1)) == cnt_q) begin
          c_raddr = ChdAw'(cnt_q);
          state_d = StLkChild;
        end else begin
          idx_d   = idx_q + CntW'(1);
          k_raddr = KeyAw'(idx_q + CntW'(1));
        end
      end
      StLkChild: begin
        out_load = 1'b1;
        out_d    = '{KindLookup, req_q.key, c_rdata, 5'(cnt_q), 1'b1};
        state_d  = StIdle;
      end
      StShift: begin
        if (k_rdata > req_q.key) begin
          k_we    = 1'b1;
          k_waddr = KeyAw'(idx_q) + KeyAw'(1);
          k_wdata = k_rdata;
          c_we    = 1'b1;
          c_waddr = ChdAw'(idx_q) + ChdAw'(2);
          c_wdata = c_rdata;
          if (idx_q == CntW'(0)) begin
            pos_d   = '0;
            state_d = StPut;
          end else begin
            idx_d   = idx_q - CntW'(1);
            k_raddr = KeyAw'(idx_q - CntW'(1));
            c_raddr = ChdAw'(idx_q);
          end
        end else begin
          pos_d   = idx_q + CntW'(1);
          state_d = StPut;
        end
      end
      StPut: begin
        k_we    = 1'b1;
        k_waddr = KeyAw'(pos_q);
        k_wdata = req_q.key;
        c_we    = 1'b1;
        c_waddr = ChdAw'(pos_q) + ChdAw'(1);
        c_wdata = req_q.child;
        if (cnt_q < CntW'(KeySlots)) begin
          cnt_d    = cnt_q + CntW'(1);
          out_load = 1'b1;
          out_d    = '{KindDone, req_q.key, req_q.child, 5'(cnt_q + CntW'(1)), 1'b1};
          state_d  = StIdle;
        end else begin
          cnt_d   = CntW'(Mid);
          idx_d   = CntW'(Mid);
          state_d = StSplitRd;
        end
      end
      StSplitRd: begin
        c_raddr = ChdAw'(idx_q) + ChdAw'(1);
        state_d = StSplitOut;
      end
      StSplitOut: begin
        c_raddr = ChdAw'(idx_q) + ChdAw'(1);
        if (out_free) begin
          out_load     = 1'b1;
          out_d.kind   = (idx_q == CntW'(Mid)) ? KindSplit : KindMoved;
          out_d.key_res   = k_rdata;
          out_d.child_res = c_rdata;
          out_d.count  = 5'(Mid);
          out_d.last   = (idx_q == CntW'(KeySlots));
          if (idx_q == CntW'(KeySlots)) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = StSplitRd;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `BTNI_ASSERT(a_cnt_range, cnt_q <= CntW'(KeySlots), "key count beyond node capacity")
  `BTNI_ASSERT(a_acc_empty, !in_acc || !out_valid_q, "request taken while a result waits")
  `BTNI_ASSERT(a_shift_nonempty, state_q != StShift || cnt_q != CntW'(0), "shift in empty node")
  `BTNI_ASSERT_NEXT(a_load_free, out_load && (state_q == StSplitOut), out_valid_q,
                    "split result lost")

endmodule

[hdl/btni_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module btni_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
